FILE: hdl/hti_pkg.sv
// ----------------------------------------------------------------------------
// hti_pkg: shared constants for the hashed trie sequence interner
// Default sizes, field widths, request codes and hash mixing constants.
// ----------------------------------------------------------------------------
package hti_pkg;
  localparam int MAX_NODES_DEF   = 1024;
  localparam int TABLE_SLOTS_DEF = 2048;
  localparam int LABEL_BITS_DEF  = 32;
  localparam int LABEL_W         = 32;
  localparam int NODE_ID_W       = 10;
  localparam logic REQ_APPEND    = 1'b0;
  localparam logic REQ_CLOSE     = 1'b1;
  localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;
endpackage

FILE: hdl/hashed_trie_sequence_interner.sv
// ----------------------------------------------------------------------------
// hashed_trie_sequence_interner: label sequence interner
// Prefix tree of label sequences kept in a linear-probing hash table.
// ----------------------------------------------------------------------------
// Usage:
//   in channel: one request per item; tuser = req_type (0 append, 1 close),
//   tdata = label. out channel: one result per request; tuser = {status,
//   created}, tdata = node_id (low bits).
//   After reset a clearing pass walks the slot table, one slot a cycle, through
//   all TABLE_SLOTS slots (2048 by default); in_tready stays low meanwhile.
//   Close is accepted and then handed over. Append is accepted and hashed (two
//   64-bit multiplies, each cut into 32x32 partial products split over states
//   S_H1/S_H2 and S_H3/S_H4, then the slot reduction in S_H5), then finds an
//   empty slot (slot read) or checks an occupied one (slot read, node read,
//   compare), and hands the result over; each collided slot repeats the slot
//   read, node read and compare. A table size that is not a power of two adds
//   folding and reciprocal reduction steps (S_MOD, S_MQ, S_MR, S_MC).
//   One request is in flight at a time. A result sits in an output register;
//   the next request is taken while it waits, and the block holds before
//   handing over a new result until the previous one is taken.
//   Running out of nodes or slots sets a sticky error; every later result
//   then reads node_id 0 with status 1, until reset.
module hashed_trie_sequence_interner #(
  parameter int MAX_NODES   = hti_pkg::MAX_NODES_DEF,
  parameter int TABLE_SLOTS = hti_pkg::TABLE_SLOTS_DEF,
  parameter int LABEL_BITS  = hti_pkg::LABEL_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] label
  input  logic        in_tuser,   // [0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [9:0] node_id, rest zero
  output logic [1:0]  out_tuser   // [0] created, [1] status
);
  localparam int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int SW = $clog2(TABLE_SLOTS);
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int PW = $clog2(TABLE_SLOTS + 1);
  localparam int OW = hti_pkg::NODE_ID_W;
  // 2^32 mod TABLE_SLOTS and floor(2^32 / TABLE_SLOTS)
  localparam logic [31:0] RED_R = 32'((64'd1 << 32) % TABLE_SLOTS);
  localparam logic [31:0] RED_M = 32'((64'd1 << 32) / TABLE_SLOTS);

  localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_H1 = 4'd2, S_H2 = 4'd3,
    S_H3 = 4'd4, S_H4 = 4'd5, S_H5 = 4'd6, S_MOD = 4'd7, S_RS = 4'd8,
    S_RN = 4'd9, S_CMP = 4'd10, S_OUT = 4'd11, S_MQ = 4'd12, S_MR = 4'd13,
    S_MC = 4'd14;

  // Memories
  logic [NW:0]  slot_mem [TABLE_SLOTS];   // {valid, node}
  logic [NW-1:0] par_mem [MAX_NODES];
  logic [LABEL_BITS-1:0] lab_mem [MAX_NODES];
  logic [NW:0]  slot_q;
  logic [NW-1:0] par_q;
  logic [LABEL_BITS-1:0] lab_q;

  logic [3:0]  state_r, state_nxt;
  logic [SW-1:0] addr_r, addr_nxt;
  logic [PW-1:0] probes_r, probes_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [NW-1:0] cur_r, cur_nxt;
  logic        err_r, err_nxt;
  logic [LABEL_BITS-1:0] lab_r, lab_nxt;
  logic [63:0] v_r, v_nxt;
  logic [63:0] p_r, p_nxt;       // partial product holder
  logic        ov_r, ov_nxt;
  logic [NW-1:0] onode_r, onode_nxt;
  logic        ocr_r, ocr_nxt, ost_r, ost_nxt;
  logic [NW-1:0] res_node_r, res_node_nxt;
  logic        res_cr_r, res_cr_nxt, res_st_r, res_st_nxt;
  logic        slot_we, node_we;
  logic [NW:0] slot_wd;
  logic [SW-1:0] raddr;

  function automatic logic [63:0] mul32(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] prod;
    prod = {32'd0, a} * {32'd0, b};
    return prod;
  endfunction

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = 16'(OW'(onode_r));
  assign out_tuser  = {ost_r, ocr_r};

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[addr_r] <= slot_wd;
    slot_q <= slot_mem[raddr];
    if (node_we) begin
      par_mem[count_r[NW-1:0]] <= cur_r;
      lab_mem[count_r[NW-1:0]] <= lab_r;
    end
    par_q <= par_mem[slot_q[NW-1:0]];
    lab_q <= lab_mem[slot_q[NW-1:0]];
  end

  assign raddr = addr_r;

  always_comb begin
    state_nxt = state_r; addr_nxt = addr_r; probes_nxt = probes_r;
    count_nxt = count_r; cur_nxt = cur_r; err_nxt = err_r; lab_nxt = lab_r;
    v_nxt = v_r; p_nxt = p_r; ov_nxt = ov_r; onode_nxt = onode_r;
    ocr_nxt = ocr_r; ost_nxt = ost_r;
    res_node_nxt = res_node_r; res_cr_nxt = res_cr_r; res_st_nxt = res_st_r;
    slot_we = 1'b0; node_we = 1'b0; slot_wd = '0;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    unique case (state_r)
      S_CLR: begin
        slot_we = 1'b1;
        addr_nxt = addr_r + 1'b1;
        if (addr_r == SW'(TABLE_SLOTS - 1)) begin
          addr_nxt = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: if (in_tvalid) begin
        lab_nxt = in_tdata[LABEL_BITS-1:0];
        if (in_tuser == hti_pkg::REQ_CLOSE) begin
          res_node_nxt = err_r ? '0 : cur_r;
          res_cr_nxt = 1'b0; res_st_nxt = err_r;
          cur_nxt = '0;
          state_nxt = S_OUT;
        end else if (err_r) begin
          res_node_nxt = '0; res_cr_nxt = 1'b0; res_st_nxt = 1'b1;
          state_nxt = S_OUT;
        end else begin
          v_nxt = {32'(cur_r), 32'(in_tdata[LABEL_BITS-1:0])};
          v_nxt = v_nxt ^ (v_nxt >> 30);
          state_nxt = S_H1;
        end
      end
      S_H1: begin  // low partial product and cross term a_hi*c_lo
        p_nxt = mul32(v_r[31:0], hti_pkg::MIX_C1[31:0])
              + {32'(v_r[63:32] * hti_pkg::MIX_C1[31:0]), 32'd0};
        state_nxt = S_H2;
      end
      S_H2: begin
        v_nxt = p_r + {32'(v_r[31:0] * hti_pkg::MIX_C1[63:32]), 32'd0};
        v_nxt = v_nxt ^ (v_nxt >> 27);
        state_nxt = S_H3;
      end
      S_H3: begin
        p_nxt = mul32(v_r[31:0], hti_pkg::MIX_C2[31:0])
              + {32'(v_r[63:32] * hti_pkg::MIX_C2[31:0]), 32'd0};
        state_nxt = S_H4;
      end
      S_H4: begin
        v_nxt = p_r + {32'(v_r[31:0] * hti_pkg::MIX_C2[63:32]), 32'd0};
        v_nxt = v_nxt ^ (v_nxt >> 31);
        state_nxt = S_H5;
      end
      S_H5: begin
        // reduce modulo table size
        if ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0) begin
          addr_nxt = v_r[SW-1:0];
          state_nxt = S_RS;
        end else begin
          p_nxt = v_r;
          state_nxt = S_MOD;
        end
        probes_nxt = '0;
      end
      S_MOD: begin
        // fold the upper word back in until the value fits 32 bits
        if (p_r[63:32] != 32'd0) begin
          p_nxt = mul32(p_r[63:32], RED_R) + {32'd0, p_r[31:0]};
        end else begin
          state_nxt = S_MQ;
        end
      end
      S_MQ: begin
        v_nxt = mul32(p_r[31:0], RED_M);
        state_nxt = S_MR;
      end
      S_MR: begin
        p_nxt = {32'd0, p_r[31:0] - 32'(mul32(v_r[63:32], 32'(TABLE_SLOTS)))};
        state_nxt = S_MC;
      end
      S_MC: begin
        if (p_r[31:0] >= 32'(TABLE_SLOTS)) begin
          p_nxt = p_r - 64'(TABLE_SLOTS);
        end else begin
          addr_nxt = p_r[SW-1:0];
          state_nxt = S_RS;
        end
      end
      S_RS: state_nxt = S_RN;
      S_RN: begin
        if (!slot_q[NW]) begin
          if (count_r >= CW'(MAX_NODES)) begin
            err_nxt = 1'b1; res_node_nxt = '0; res_cr_nxt = 1'b0; res_st_nxt = 1'b1;
          end else begin
            slot_we = 1'b1;
            slot_wd = {1'b1, count_r[NW-1:0]};
            node_we = 1'b1;
            count_nxt = count_r + 1'b1;
            cur_nxt = count_r[NW-1:0];
            res_node_nxt = count_r[NW-1:0]; res_cr_nxt = 1'b1; res_st_nxt = 1'b0;
          end
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (par_q == cur_r && lab_q == lab_r) begin
          cur_nxt = slot_q[NW-1:0];
          res_node_nxt = slot_q[NW-1:0]; res_cr_nxt = 1'b0; res_st_nxt = 1'b0;
          state_nxt = S_OUT;
        end else if (probes_r == PW'(TABLE_SLOTS - 1)) begin
          err_nxt = 1'b1; res_node_nxt = '0; res_cr_nxt = 1'b0; res_st_nxt = 1'b1;
          state_nxt = S_OUT;
        end else begin
          probes_nxt = probes_r + 1'b1;
          addr_nxt = (addr_r == SW'(TABLE_SLOTS - 1)) ? '0 : addr_r + 1'b1;
          state_nxt = S_RS;
        end
      end
      S_OUT: begin
        // hold the staged result until the register frees up
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1;
          onode_nxt = res_node_r; ocr_nxt = res_cr_r; ost_nxt = res_st_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR; addr_r <= '0; probes_r <= '0;
      count_r <= CW'(1); cur_r <= '0; err_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; addr_r <= addr_nxt; probes_r <= probes_nxt;
      count_r <= count_nxt; cur_r <= cur_nxt; err_r <= err_nxt; ov_r <= ov_nxt;
    end
    lab_r <= lab_nxt; v_r <= v_nxt; p_r <= p_nxt;
    onode_r <= onode_nxt; ocr_r <= ocr_nxt; ost_r <= ost_nxt;
    res_node_r <= res_node_nxt; res_cr_r <= res_cr_nxt; res_st_r <= res_st_nxt;
  end
endmodule

FILE: dv/hashed_trie_sequence_interner_test.sv
// ----------------------------------------------------------------------------
// hashed_trie_sequence_interner_test: self-checking bench for the interner
// Drives append and close requests, predicts node numbers with an own copy
// of the hashed prefix tree, and compares every result field by field.
// ----------------------------------------------------------------------------
module hashed_trie_sequence_interner_test;

  localparam int NODES = hti_pkg::MAX_NODES_DEF;
  localparam int SLOTS = hti_pkg::TABLE_SLOTS_DEF;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic [hti_pkg::NODE_ID_W-1:0] node_id;
    logic                          created;
    logic                          status;
  } intern_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;

  // trie copy
  logic [10:0] slot_node [SLOTS];
  logic        slot_used [SLOTS];
  logic [9:0]  parent_of [NODES];
  logic [31:0] label_of [NODES];
  int          node_total;
  logic [9:0]  cur_node;
  logic        sticky_err;

  intern_result_t pending_results[$];
  int  fails;
  int  send_idle_pct;
  int  recv_idle_pct;
  int  hold_off_cycles;
  int  quiet_cycles;
  int  known_labels[$];

  hashed_trie_sequence_interner i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] splitmix(logic [9:0] par, logic [31:0] lab);
    logic [63:0] v;
    v = {22'd0, par, lab};
    v = v ^ (v >> 30);
    v = v * hti_pkg::MIX_C1;
    v = v ^ (v >> 27);
    v = v * hti_pkg::MIX_C2;
    return v ^ (v >> 31);
  endfunction

  function automatic intern_result_t intern_predict(logic kind, logic [31:0] lab);
    intern_result_t r;
    int slot;
    logic [9:0] term;
    r = '0;
    if (kind == hti_pkg::REQ_CLOSE) begin
      term = cur_node;
      cur_node = '0;
      if (sticky_err) r.status = 1'b1;
      else r.node_id = term;
      return r;
    end
    if (sticky_err) begin
      r.status = 1'b1;
      return r;
    end
    slot = int'(splitmix(cur_node, lab) % SLOTS);
    for (int p = 0; p < SLOTS; p++) begin
      if (!slot_used[slot]) begin
        if (node_total >= NODES) break;
        parent_of[node_total] = cur_node;
        label_of[node_total] = lab;
        slot_node[slot] = 11'(node_total);
        slot_used[slot] = 1'b1;
        cur_node = 10'(node_total);
        node_total++;
        r.node_id = cur_node;
        r.created = 1'b1;
        return r;
      end else if (slot_node[slot] < NODES && parent_of[slot_node[slot]] == cur_node
                   && label_of[slot_node[slot]] == lab) begin
        cur_node = slot_node[slot][9:0];
        r.node_id = cur_node;
        return r;
      end
      slot = (slot + 1) % SLOTS;
    end
    sticky_err = 1'b1;
    r.status = 1'b1;
    return r;
  endfunction

  // leaves in_tvalid high after the accepting edge; the next wait drops it
  task automatic send_request(logic kind, logic [31:0] lab);
    intern_result_t exp_r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= lab;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    exp_r = intern_predict(kind, lab);
    pending_results = {pending_results, exp_r};
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_label();
    if (known_labels.size() != 0 && $urandom_range(99) < 70)
      return known_labels[$urandom_range(known_labels.size() - 1)];
    return $urandom();
  endfunction

  // receiver with random stalls and an optional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    intern_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result node_id=%0d", out_tdata[9:0]);
        fails++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_tdata[9:0] !== exp_r.node_id) begin
          $error("node_id expected %0d actual %0d", exp_r.node_id, out_tdata[9:0]);
          fails++;
        end
        if (out_tuser[0] !== exp_r.created) begin
          $error("created expected %0d actual %0d", exp_r.created, out_tuser[0]);
          fails++;
        end
        if (out_tuser[1] !== exp_r.status) begin
          $error("status expected %0d actual %0d", exp_r.status, out_tuser[1]);
          fails++;
        end
      end
    end
  end

  // watchdog: cycles with no handshake on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WATCHDOG + SLOTS) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic test_directed();
    send_request(hti_pkg::REQ_CLOSE, 32'h0);            // empty sequence
    send_request(hti_pkg::REQ_APPEND, 32'h0);
    send_request(hti_pkg::REQ_APPEND, 32'hFFFF_FFFF);
    send_request(hti_pkg::REQ_CLOSE, 32'hFFFF_FFFF);    // label ignored on close
    send_request(hti_pkg::REQ_APPEND, 32'h0);           // revisit existing path
    send_request(hti_pkg::REQ_APPEND, 32'hFFFF_FFFF);
    send_request(hti_pkg::REQ_CLOSE, 32'h0);
    send_request(hti_pkg::REQ_APPEND, 32'hAAAA_AAAA);
    send_request(hti_pkg::REQ_APPEND, 32'h5555_5555);
    send_request(hti_pkg::REQ_APPEND, 32'h8000_0001);
    send_request(hti_pkg::REQ_CLOSE, 32'h1234_5678);
    drain_results();
  endtask

  task automatic test_random(int count);
    int len;
    int sent;
    sent = 0;
    while (sent < count) begin
      len = $urandom_range(0, 6);
      for (int k = 0; k < len; k++) begin
        send_request(hti_pkg::REQ_APPEND, pick_label());
        sent++;
      end
      send_request(hti_pkg::REQ_CLOSE, $urandom());
      sent++;
    end
  endtask

  task automatic test_backpressure();
    hold_off_cycles = 300;
    for (int k = 0; k < 20; k++) send_request(hti_pkg::REQ_APPEND, pick_label());
    send_request(hti_pkg::REQ_CLOSE, 32'h0);
    drain_results();
  endtask

  initial begin
    fails = 0;
    quiet_cycles = 0;
    hold_off_cycles = 0;
    send_idle_pct = 19;
    recv_idle_pct = 64;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = hti_pkg::REQ_APPEND;
    for (int s = 0; s < SLOTS; s++) begin
      slot_used[s] = 1'b0;
      slot_node[s] = '0;
    end
    node_total = 1;
    cur_node = '0;
    sticky_err = 1'b0;
    for (int k = 0; k < 16; k++)
      known_labels = {known_labels, int'($urandom_range(0, 3) * 32'h4000_0001)};
    known_labels = {known_labels, int'(32'h0)};
    known_labels = {known_labels, int'(32'hFFFF_FFFF)};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random(200);
    test_backpressure();
    drain_results();
    send_idle_pct = 64;
    recv_idle_pct = 19;
    test_random(200);
    drain_results();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(250);
    drain_results();

    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
